@@ hw/rtl/encoder_speed_pid_pwm_controller_defines.svh @@
// assertion macros for the encoder speed pid controller
`ifndef ENCODER_SPEED_PID_PWM_CONTROLLER_DEFINES_SVH
`define ENCODER_SPEED_PID_PWM_CONTROLLER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define ESPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define ESPC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/espc_pkg.sv @@
// shared types and constants of the encoder speed pid controller
`timescale 1ns / 1ps

package espc_pkg;

    // stream and config port widths
    localparam int MOTOR_W    = 2;
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 72;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_FULL    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTS_TO_RPM = 3'd5;

    // config reset values
    localparam logic [23:0] RST_PROP_GAIN     = 24'd39322;
    localparam logic [23:0] RST_INTEG_GAIN    = 24'd655;
    localparam logic [23:0] RST_DERIV_GAIN    = 24'd0;
    localparam logic [15:0] RST_INTEGRAL_LIM  = 16'd2000;
    localparam logic [15:0] RST_PULSE_FULL    = 16'd999;
    localparam logic [23:0] RST_COUNTS_TO_RPM = 24'd893673;

    // shift-add multiplier
    localparam int MUL_A_W   = 64;
    localparam int MUL_B_W   = 24;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    // long division by a constant
    localparam int DIV_W     = 56;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int REM_W     = 7;
    localparam logic [REM_W:0] DIVISOR = 8'd100;

    // multiplier operand for the derivative time scale
    localparam logic [MUL_B_W-1:0] HUNDRED_B = 24'd100;

    // derivative saturation: limit / 100 and limit
    localparam logic [63:0] D_THRESH = 64'd23058430092136939;
    localparam logic [63:0] D_SAT    = 64'h2000_0000_0000_0000;

    // full duty in Q.24
    localparam logic [63:0] DUTY_FULL = 64'd1677721600;
    localparam logic [63:0] DUTY_NEG  = ~DUTY_FULL + 64'd1;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic [MUL_A_W-1:0] prod;
    } mul_rsp_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } div_rsp_t;

    typedef enum logic [15:0] {
        ST_IDLE  = 16'h0001,
        ST_CHECK = 16'h0002,
        ST_MEAS  = 16'h0004,
        ST_ERR   = 16'h0008,
        ST_SUM   = 16'h0010,
        ST_PMUL  = 16'h0020,
        ST_IMUL  = 16'h0040,
        ST_IDIV  = 16'h0080,
        ST_DMUL  = 16'h0100,
        ST_DCHK  = 16'h0200,
        ST_D100  = 16'h0400,
        ST_CLAMP = 16'h0800,
        ST_CMD   = 16'h1000,
        ST_PULSE = 16'h2000,
        ST_PDIV  = 16'h4000,
        ST_OUT   = 16'h8000
    } state_t;

endpackage

@@ hw/rtl/espc_mul.sv @@
// bit-serial shift-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps

module espc_mul (
    input  logic              aclk,
    input  logic              aresetn,
    input  espc_pkg::mul_req_t req,
    output espc_pkg::mul_rsp_t rsp
);

    localparam logic [espc_pkg::MUL_CNT_W-1:0] LAST_STEP =
        espc_pkg::MUL_CNT_W'(espc_pkg::MUL_B_W - 1);

    logic                             busy_reg;
    logic                             done_reg;
    logic [espc_pkg::MUL_CNT_W-1:0]   cnt_reg;
    logic [espc_pkg::MUL_A_W-1:0]     a_reg;
    logic [espc_pkg::MUL_B_W-1:0]     b_reg;
    logic [espc_pkg::MUL_A_W-1:0]     acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // partial product added when the low multiplier bit is set
    always_ff @(posedge aclk) begin
        if (req.start) begin
            acc_reg <= '0;
            a_reg   <= req.a;
            b_reg   <= req.b;
        end else if (busy_reg) begin
            if (b_reg[0]) begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= {a_reg[espc_pkg::MUL_A_W-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[espc_pkg::MUL_B_W-1:1]};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

@@ hw/rtl/espc_div.sv @@
// restoring division by one hundred, one quotient bit per cycle
`timescale 1ns / 1ps

module espc_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  espc_pkg::div_req_t req,
    output espc_pkg::div_rsp_t rsp
);

    localparam logic [espc_pkg::DIV_CNT_W-1:0] LAST_STEP =
        espc_pkg::DIV_CNT_W'(espc_pkg::DIV_W - 1);

    logic                             busy_reg;
    logic                             done_reg;
    logic [espc_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [espc_pkg::DIV_W-1:0]       num_reg;
    logic [espc_pkg::DIV_W-1:0]       quot_reg;
    logic [espc_pkg::REM_W-1:0]       rem_reg;

    logic [espc_pkg::REM_W:0]         trial;
    logic                             fits;
    logic [espc_pkg::REM_W:0]         trial_sub;

    assign trial     = {rem_reg, num_reg[espc_pkg::DIV_W-1]};
    assign fits      = (trial >= espc_pkg::DIVISOR);
    assign trial_sub = trial - espc_pkg::DIVISOR;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg  <= req.num;
            quot_reg <= '0;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            num_reg  <= {num_reg[espc_pkg::DIV_W-2:0], 1'b0};
            quot_reg <= {quot_reg[espc_pkg::DIV_W-2:0], fits};
            rem_reg  <= fits ? trial_sub[espc_pkg::REM_W-1:0] : trial[espc_pkg::REM_W-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

@@ hw/rtl/encoder_speed_pid_pwm_controller.sv @@
// encoder speed pid controller: top level with tick sequencer and per-motor state
`timescale 1ns / 1ps
// throughput: one tick at a time, next input transfer in the cycle after the result is loaded;
// each tick runs six 24-step multiplier passes (five with the derivative saturated)
// and two 56-step divide-by-100 passes; an out-of-range motor index runs none of them
// reset: aresetn synchronous active low, restores register defaults and clears motor state
`include "encoder_speed_pid_pwm_controller_defines.svh"

module encoder_speed_pid_pwm_controller #(
    parameter int MOTORS = 3
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [espc_pkg::S_DATA_W-1:0]       s_tdata,   // encoder_count, setpoint_rpm
    input  logic [espc_pkg::MOTOR_W-1:0]        s_tuser,   // motor
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // measured_rpm, drive_command, forward_compare, reverse_compare
    output logic [espc_pkg::M_DATA_W-1:0]       m_tdata,
    output logic [espc_pkg::MOTOR_W-1:0]        m_tuser,   // motor_echo
    // config write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [espc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [espc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int MIDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;

    // config registers
    logic [23:0] prop_gain_reg;
    logic [23:0] integ_gain_reg;
    logic [23:0] deriv_gain_reg;
    logic [15:0] integral_limit_reg;
    logic [15:0] pulse_full_scale_reg;
    logic [23:0] counts_to_rpm_reg;

    // per-motor loop state
    logic [15:0] prev_count_reg [MOTORS];
    logic [31:0] err_sum_reg    [MOTORS];
    logic [31:0] prev_err_reg   [MOTORS];

    espc_pkg::state_t state_reg;
    espc_pkg::state_t state_next;

    // tick working registers
    logic [espc_pkg::MOTOR_W-1:0] motor_reg;
    logic [15:0] count_reg;
    logic [31:0] target_reg;
    logic        neg_reg;       // sign of the operand now in the multiplier
    logic [31:0] measured_reg;
    logic [31:0] error_reg;
    logic [31:0] lim_reg;
    logic [31:0] sum_reg;
    logic [32:0] diff_reg;
    logic [63:0] acc_reg;       // p + i + d in Q.24
    logic [63:0] dmag_reg;
    logic        dsat_reg;
    logic [31:0] tot_reg;
    logic [7:0]  cmd_reg;
    logic [15:0] fwd_reg;
    logic [15:0] rev_reg;

    // output register
    logic                                m_tvalid_reg;
    logic [espc_pkg::M_DATA_W-1:0]       m_tdata_reg;
    logic [espc_pkg::MOTOR_W-1:0]        m_tuser_reg;

    espc_pkg::mul_req_t mul_req;
    espc_pkg::mul_rsp_t mul_rsp;
    espc_pkg::div_req_t div_req;
    espc_pkg::div_rsp_t div_rsp;

    logic [MIDX_W-1:0] midx;
    logic              in_range;
    logic              out_free;

    logic [15:0] delta;
    logic [15:0] delta_mag;
    logic [31:0] meas_mag;
    logic [32:0] err_ext;
    logic [31:0] err_sat;
    logic [31:0] lim_val;
    logic [31:0] err_sum_sel;
    logic [31:0] prev_err_sel;
    logic [32:0] sum_ext;
    logic [32:0] lim_pos;
    logic [32:0] lim_neg;
    logic [31:0] sum_val;
    logic [32:0] diff_val;
    logic [31:0] err_mag;
    logic [31:0] sum_mag;
    logic [32:0] diff_mag;
    logic [63:0] prod_signed;
    logic [63:0] quot_ext;
    logic [63:0] quot_signed;
    logic [63:0] dsat_signed;
    logic [31:0] tot_mag;
    logic [6:0]  cmd_mag;

    espc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    espc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign midx     = MIDX_W'(motor_reg);
    assign in_range = (32'(motor_reg) < 32'(MOTORS));
    assign out_free = !m_tvalid_reg || m_tready;

    assign s_tready  = (state_reg == espc_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    // speed from the wrapping count step
    assign delta     = count_reg - prev_count_reg[midx];
    assign delta_mag = delta[15] ? (~delta + 16'd1) : delta;
    assign meas_mag  = mul_rsp.prod[39:8];

    // speed error, saturated to 32 bits
    assign err_ext = {target_reg[31], target_reg} - {measured_reg[31], measured_reg};
    always_comb begin
        if (err_ext[32] != err_ext[31]) begin
            err_sat = err_ext[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            err_sat = err_ext[31:0];
        end
    end

    // integral limit times 25600
    assign lim_val = 32'({integral_limit_reg, 14'd0}) + 32'({integral_limit_reg, 13'd0})
                   + 32'({integral_limit_reg, 10'd0});

    // error sum with anti-windup clamp
    assign err_sum_sel  = err_sum_reg[midx];
    assign prev_err_sel = prev_err_reg[midx];
    assign sum_ext  = {err_sum_sel[31], err_sum_sel} + {error_reg[31], error_reg};
    assign lim_pos  = {1'b0, lim_reg};
    assign lim_neg  = ~lim_pos + 33'd1;
    always_comb begin
        if ($signed(sum_ext) > $signed(lim_pos)) begin
            sum_val = lim_pos[31:0];
        end else if ($signed(sum_ext) < $signed(lim_neg)) begin
            sum_val = lim_neg[31:0];
        end else begin
            sum_val = sum_ext[31:0];
        end
    end
    assign diff_val = {error_reg[31], error_reg} - {prev_err_sel[31], prev_err_sel};

    // operand magnitudes for the unsigned multiplier
    assign err_mag  = error_reg[31] ? (~error_reg + 32'd1) : error_reg;
    assign sum_mag  = sum_reg[31] ? (~sum_reg + 32'd1) : sum_reg;
    assign diff_mag = diff_reg[32] ? (~diff_reg + 33'd1) : diff_reg;

    // sign restored on the way back
    assign prod_signed = neg_reg ? (~mul_rsp.prod + 64'd1) : mul_rsp.prod;
    assign quot_ext    = 64'(div_rsp.quot);
    assign quot_signed = neg_reg ? (~quot_ext + 64'd1) : quot_ext;
    assign dsat_signed = neg_reg ? (~espc_pkg::D_SAT + 64'd1) : espc_pkg::D_SAT;

    // whole percent, truncated toward zero
    assign tot_mag = tot_reg[31] ? (~tot_reg + 32'd1) : tot_reg;
    assign cmd_mag = tot_mag[30:24];

    // sequencer and unit requests
    always_comb begin
        state_next = state_reg;
        mul_req    = '0;
        div_req    = '0;
        case (state_reg)
            espc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = espc_pkg::ST_CHECK;
                end
            end
            espc_pkg::ST_CHECK: begin
                if (!in_range) begin
                    state_next = espc_pkg::ST_OUT;
                end else begin
                    mul_req.start = 1'b1;
                    mul_req.a     = 64'(delta_mag);
                    mul_req.b     = counts_to_rpm_reg;
                    state_next    = espc_pkg::ST_MEAS;
                end
            end
            espc_pkg::ST_MEAS: begin
                if (mul_rsp.done) begin
                    state_next = espc_pkg::ST_ERR;
                end
            end
            espc_pkg::ST_ERR: begin
                state_next = espc_pkg::ST_SUM;
            end
            espc_pkg::ST_SUM: begin
                mul_req.start = 1'b1;
                mul_req.a     = 64'(err_mag);
                mul_req.b     = prop_gain_reg;
                state_next    = espc_pkg::ST_PMUL;
            end
            espc_pkg::ST_PMUL: begin
                if (mul_rsp.done) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = 64'(sum_mag);
                    mul_req.b     = integ_gain_reg;
                    state_next    = espc_pkg::ST_IMUL;
                end
            end
            espc_pkg::ST_IMUL: begin
                if (mul_rsp.done) begin
                    div_req.start = 1'b1;
                    div_req.num   = mul_rsp.prod[espc_pkg::DIV_W-1:0];
                    state_next    = espc_pkg::ST_IDIV;
                end
            end
            espc_pkg::ST_IDIV: begin
                if (div_rsp.done) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = 64'(diff_mag);
                    mul_req.b     = deriv_gain_reg;
                    state_next    = espc_pkg::ST_DMUL;
                end
            end
            espc_pkg::ST_DMUL: begin
                if (mul_rsp.done) begin
                    state_next = espc_pkg::ST_DCHK;
                end
            end
            espc_pkg::ST_DCHK: begin
                if (dsat_reg) begin
                    state_next = espc_pkg::ST_CLAMP;
                end else begin
                    mul_req.start = 1'b1;
                    mul_req.a     = dmag_reg;
                    mul_req.b     = espc_pkg::HUNDRED_B;
                    state_next    = espc_pkg::ST_D100;
                end
            end
            espc_pkg::ST_D100: begin
                if (mul_rsp.done) begin
                    state_next = espc_pkg::ST_CLAMP;
                end
            end
            espc_pkg::ST_CLAMP: begin
                state_next = espc_pkg::ST_CMD;
            end
            espc_pkg::ST_CMD: begin
                mul_req.start = 1'b1;
                mul_req.a     = 64'(cmd_mag);
                mul_req.b     = 24'(pulse_full_scale_reg);
                state_next    = espc_pkg::ST_PULSE;
            end
            espc_pkg::ST_PULSE: begin
                if (mul_rsp.done) begin
                    div_req.start = 1'b1;
                    div_req.num   = mul_rsp.prod[espc_pkg::DIV_W-1:0];
                    state_next    = espc_pkg::ST_PDIV;
                end
            end
            espc_pkg::ST_PDIV: begin
                if (div_rsp.done) begin
                    state_next = espc_pkg::ST_OUT;
                end
            end
            espc_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = espc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = espc_pkg::ST_IDLE;
            end
        endcase
    end

    // control state, config and per-motor state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg            <= espc_pkg::ST_IDLE;
            m_tvalid_reg         <= 1'b0;
            prop_gain_reg        <= espc_pkg::RST_PROP_GAIN;
            integ_gain_reg       <= espc_pkg::RST_INTEG_GAIN;
            deriv_gain_reg       <= espc_pkg::RST_DERIV_GAIN;
            integral_limit_reg   <= espc_pkg::RST_INTEGRAL_LIM;
            pulse_full_scale_reg <= espc_pkg::RST_PULSE_FULL;
            counts_to_rpm_reg    <= espc_pkg::RST_COUNTS_TO_RPM;
            for (int i = 0; i < MOTORS; i++) begin
                prev_count_reg[i] <= '0;
                err_sum_reg[i]    <= '0;
                prev_err_reg[i]   <= '0;
            end
        end else begin
            state_reg <= state_next;

            if (state_reg == espc_pkg::ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_valid) begin
                case (cfg_index)
                    espc_pkg::REG_PROP_GAIN:     prop_gain_reg        <= cfg_data;
                    espc_pkg::REG_INTEG_GAIN:    integ_gain_reg       <= cfg_data;
                    espc_pkg::REG_DERIV_GAIN:    deriv_gain_reg       <= cfg_data;
                    espc_pkg::REG_INTEGRAL_LIM:  integral_limit_reg   <= cfg_data[15:0];
                    espc_pkg::REG_PULSE_FULL:    pulse_full_scale_reg <= cfg_data[15:0];
                    espc_pkg::REG_COUNTS_TO_RPM: counts_to_rpm_reg    <= cfg_data;
                    default: ;
                endcase
            end

            if (state_reg == espc_pkg::ST_CHECK && in_range) begin
                prev_count_reg[midx] <= count_reg;
            end
            if (state_reg == espc_pkg::ST_SUM) begin
                err_sum_reg[midx]  <= sum_val;
                prev_err_reg[midx] <= error_reg;
            end
        end
    end

    // tick datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            espc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    motor_reg  <= s_tuser;
                    count_reg  <= s_tdata[15:0];
                    target_reg <= s_tdata[47:16];
                end
            end
            espc_pkg::ST_CHECK: begin
                neg_reg <= delta[15];
                if (!in_range) begin
                    measured_reg <= '0;
                    cmd_reg      <= '0;
                    fwd_reg      <= '0;
                    rev_reg      <= '0;
                end
            end
            espc_pkg::ST_MEAS: begin
                if (mul_rsp.done) begin
                    measured_reg <= neg_reg ? (~meas_mag + 32'd1) : meas_mag;
                end
            end
            espc_pkg::ST_ERR: begin
                error_reg <= err_sat;
                lim_reg   <= lim_val;
            end
            espc_pkg::ST_SUM: begin
                sum_reg  <= sum_val;
                diff_reg <= diff_val;
                neg_reg  <= error_reg[31];
            end
            espc_pkg::ST_PMUL: begin
                if (mul_rsp.done) begin
                    acc_reg <= prod_signed;
                    neg_reg <= sum_reg[31];
                end
            end
            espc_pkg::ST_IDIV: begin
                if (div_rsp.done) begin
                    acc_reg <= acc_reg + quot_signed;
                    neg_reg <= diff_reg[32];
                end
            end
            espc_pkg::ST_DMUL: begin
                if (mul_rsp.done) begin
                    dmag_reg <= mul_rsp.prod;
                    dsat_reg <= (mul_rsp.prod > espc_pkg::D_THRESH);
                end
            end
            espc_pkg::ST_DCHK: begin
                if (dsat_reg) begin
                    acc_reg <= acc_reg + dsat_signed;
                end
            end
            espc_pkg::ST_D100: begin
                if (mul_rsp.done) begin
                    acc_reg <= acc_reg + prod_signed;
                end
            end
            espc_pkg::ST_CLAMP: begin
                if ($signed(acc_reg) > $signed(espc_pkg::DUTY_FULL)) begin
                    tot_reg <= espc_pkg::DUTY_FULL[31:0];
                end else if ($signed(acc_reg) < $signed(espc_pkg::DUTY_NEG)) begin
                    tot_reg <= espc_pkg::DUTY_NEG[31:0];
                end else begin
                    tot_reg <= acc_reg[31:0];
                end
            end
            espc_pkg::ST_CMD: begin
                cmd_reg <= tot_reg[31] ? (8'd0 - {1'b0, cmd_mag}) : {1'b0, cmd_mag};
            end
            espc_pkg::ST_PDIV: begin
                if (div_rsp.done) begin
                    // stopped counts as forward
                    fwd_reg <= cmd_reg[7] ? 16'd0 : div_rsp.quot[15:0];
                    rev_reg <= cmd_reg[7] ? div_rsp.quot[15:0] : 16'd0;
                end
            end
            espc_pkg::ST_OUT: begin
                if (out_free) begin
                    m_tuser_reg <= motor_reg;
                    m_tdata_reg <= {rev_reg, fwd_reg, cmd_reg, measured_reg};
                end
            end
            default: ;
        endcase
    end

    // checks
    `ESPC_ASSERT_NXT(a_accept_starts_tick, aclk, aresetn, s_tvalid && s_tready,
        state_reg == espc_pkg::ST_CHECK, "input transfer did not start a tick")
    `ESPC_ASSERT_IMP(a_cmd_in_range, aclk, aresetn, m_tvalid_reg,
        ($signed(m_tdata_reg[39:32]) <= 8'sd100) && ($signed(m_tdata_reg[39:32]) >= -8'sd100),
        "drive command outside plus or minus one hundred")
    `ESPC_ASSERT_IMP(a_one_channel, aclk, aresetn, m_tvalid_reg,
        (m_tdata_reg[55:40] == 16'd0) || (m_tdata_reg[71:56] == 16'd0),
        "forward and reverse compare both active")
    `ESPC_ASSERT_IMP(a_mul_done_waited, aclk, aresetn, mul_rsp.done,
        (state_reg == espc_pkg::ST_MEAS) || (state_reg == espc_pkg::ST_PMUL) ||
        (state_reg == espc_pkg::ST_IMUL) || (state_reg == espc_pkg::ST_DMUL) ||
        (state_reg == espc_pkg::ST_D100) || (state_reg == espc_pkg::ST_PULSE),
        "multiplier finished outside a waiting state")

endmodule

@@ test/encoder_speed_pid_pwm_controller_checker.sv @@
// checker for the encoder speed pid controller: predicts every tick and compares results
`timescale 1ns / 1ps

module encoder_speed_pid_pwm_controller_checker #(
    parameter int MOTORS = 3
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [espc_pkg::S_DATA_W-1:0]     s_tdata,   // encoder_count, setpoint_rpm
    input  logic [espc_pkg::MOTOR_W-1:0]      s_tuser,   // motor
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    // measured_rpm, drive_command, forward_compare, reverse_compare
    input  logic [espc_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic [espc_pkg::MOTOR_W-1:0]      m_tuser,   // motor_echo
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [espc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [espc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                fail_count,
    output int                                pending
);

    localparam longint I32_MAX   = 64'sd2147483647;
    localparam longint I32_MIN   = -64'sd2147483648;
    localparam longint FULL_DUTY = 64'sd1677721600;          // 100 percent in Q.24
    localparam longint D_CLAMP   = 64'sh2000_0000_0000_0000;
    localparam longint Q24_ONE   = 64'sd16777216;
    localparam int     MAX_LINES = 200;

    typedef struct packed {
        logic [1:0]  motor;
        logic [31:0] rpm;
        logic [7:0]  cmd;
        logic [15:0] fwd;
        logic [15:0] rev;
    } tick_result_t;

    // register copies, held zero-extended
    longint kp, ki, kd, i_limit, pulse_fs, rpm_scale;

    // per-motor loop state
    logic [15:0] last_count [MOTORS];
    int          err_sum    [MOTORS];
    int          last_err   [MOTORS];

    tick_result_t due_results[$];

    function automatic longint clip(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic int sat_int32(longint v);
        if (v > I32_MAX) return int'(I32_MAX);
        if (v < I32_MIN) return int'(I32_MIN);
        return int'(v);
    endfunction

    // one control tick: speed from count step, then p + i + d and the compare split
    function automatic tick_result_t run_pid_tick(logic [1:0] motor, logic [15:0] count,
                                                  logic [31:0] target_bits);
        tick_result_t r;
        logic [15:0]  step;
        longint       target, prod, sum, diff, p_term, i_term, d_term, total, cmd, mag;
        longint       pulse;
        int           measured, error;
        r = '0;
        r.motor = motor;
        if (motor >= MOTORS) return r;   // unknown motor leaves all state alone

        target = longint'($signed(target_bits));
        step = count - last_count[motor];
        last_count[motor] = count;
        prod = longint'($signed(step)) * rpm_scale;
        measured = sat_int32(prod / 256);   // signed divide truncates toward zero
        error = sat_int32(target - measured);

        sum = clip(longint'(err_sum[motor]) + error, i_limit * 100 * 256);
        err_sum[motor] = int'(sum);
        diff = longint'(error) - longint'(last_err[motor]);
        last_err[motor] = error;

        p_term = kp * error;
        i_term = (ki * sum) / 100;
        d_term = kd * diff;
        if (d_term > D_CLAMP / 100) d_term = D_CLAMP;
        else if (d_term < -(D_CLAMP / 100)) d_term = -D_CLAMP;
        else d_term = d_term * 100;

        total = clip(p_term + i_term + d_term, FULL_DUTY);
        cmd = total / Q24_ONE;
        mag = (cmd < 0) ? -cmd : cmd;
        pulse = (mag * pulse_fs) / 100;

        r.rpm = measured;
        r.cmd = cmd[7:0];
        r.fwd = (cmd >= 0) ? pulse[15:0] : 16'd0;
        r.rev = (cmd < 0) ? pulse[15:0] : 16'd0;
        return r;
    endfunction

    task automatic report_failure(string msg);
        if (fail_count < MAX_LINES) $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge aclk) begin : watch
        tick_result_t want;
        if (!aresetn) begin
            kp        = espc_pkg::RST_PROP_GAIN;
            ki        = espc_pkg::RST_INTEG_GAIN;
            kd        = espc_pkg::RST_DERIV_GAIN;
            i_limit   = espc_pkg::RST_INTEGRAL_LIM;
            pulse_fs  = espc_pkg::RST_PULSE_FULL;
            rpm_scale = espc_pkg::RST_COUNTS_TO_RPM;
            for (int i = 0; i < MOTORS; i++) begin
                last_count[i] = '0;
                err_sum[i]    = 0;
                last_err[i]   = 0;
            end
            due_results.delete();
        end else begin
            // results first, so a result can never match a tick taken in the same cycle
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    report_failure($sformatf("result for motor %0d with none due", m_tuser));
                end else begin
                    want = due_results.pop_front();
                    if (m_tuser !== want.motor)
                        report_failure($sformatf("motor_echo got %0d expected %0d",
                                                 m_tuser, want.motor));
                    if (m_tdata[31:0] !== want.rpm)
                        report_failure($sformatf("measured_rpm got %0d expected %0d",
                                                 $signed(m_tdata[31:0]), $signed(want.rpm)));
                    if (m_tdata[39:32] !== want.cmd)
                        report_failure($sformatf("drive_command got %0d expected %0d",
                                                 $signed(m_tdata[39:32]), $signed(want.cmd)));
                    if (m_tdata[55:40] !== want.fwd)
                        report_failure($sformatf("forward_compare got %0d expected %0d",
                                                 m_tdata[55:40], want.fwd));
                    if (m_tdata[71:56] !== want.rev)
                        report_failure($sformatf("reverse_compare got %0d expected %0d",
                                                 m_tdata[71:56], want.rev));
                end
            end
            if (s_tvalid && s_tready)
                due_results.push_back(run_pid_tick(s_tuser, s_tdata[15:0], s_tdata[47:16]));
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    espc_pkg::REG_PROP_GAIN:     kp        = cfg_data;
                    espc_pkg::REG_INTEG_GAIN:    ki        = cfg_data;
                    espc_pkg::REG_DERIV_GAIN:    kd        = cfg_data;
                    espc_pkg::REG_INTEGRAL_LIM:  i_limit   = cfg_data[15:0];
                    espc_pkg::REG_PULSE_FULL:    pulse_fs  = cfg_data[15:0];
                    espc_pkg::REG_COUNTS_TO_RPM: rpm_scale = cfg_data;
                    default: ;
                endcase
            end
        end
        pending = due_results.size();
    end

endmodule

@@ test/encoder_speed_pid_pwm_controller_tb.sv @@
// top of the encoder speed pid controller testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module encoder_speed_pid_pwm_controller_tb;

    localparam int     MOTORS          = 3;
    localparam int     LATENCY         = 271;        // slowest tick
    localparam longint CYCLE_LIMIT     = 2000000;    // several times the slowest clean run
    localparam int     PHASES          = 8;
    localparam int     TICKS_PER_PHASE = 160;
    localparam int     HOLD_CYCLES     = 800;        // long enough to back up the input side
    localparam int     MAX_GAP         = 17;

    // indexes past the register list, writes there must be dropped
    localparam logic [espc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [espc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                              aclk      = 1'b0;
    logic                              aresetn   = 1'b0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [espc_pkg::S_DATA_W-1:0]     s_tdata   = '0;   // encoder_count, setpoint_rpm
    logic [espc_pkg::MOTOR_W-1:0]      s_tuser   = '0;   // motor
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    // measured_rpm, drive_command, forward_compare, reverse_compare
    logic [espc_pkg::M_DATA_W-1:0]     m_tdata;
    logic [espc_pkg::MOTOR_W-1:0]      m_tuser;          // motor_echo
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [espc_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [espc_pkg::CFG_DATA_W-1:0]   cfg_data  = '0;

    int     fail_count;
    int     pending;
    longint cycles    = 0;
    bit     hold_req  = 1'b0;   // asks the result side for one long stall
    bit     tx_eager  = 1'b0;   // sender offers back to back
    bit     rx_eager  = 1'b0;   // result side always ready

    // last count sent per motor, so tracked ticks move the counter by sane steps
    logic [15:0] enc_pos [MOTORS] = '{default: '0};
    longint      cur_rpm_scale    = espc_pkg::RST_COUNTS_TO_RPM;

    encoder_speed_pid_pwm_controller #(
        .MOTORS(MOTORS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    encoder_speed_pid_pwm_controller_checker #(
        .MOTORS(MOTORS)
    ) speed_pid_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 100 MHz clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // watchdog: a hung handshake or a lost result ends here
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // one tick transfer on the input stream; returns at the falling edge after the transfer
    task automatic send_tick(logic [1:0] motor, logic [15:0] count, logic [31:0] target);
        int  gap;
        bit  after_result;
        gap = $urandom_range(0, MAX_GAP);
        after_result = 1'($urandom_range(0, 1));
        if (!tx_eager && (after_result || gap > 0)) begin
            s_tvalid = 1'b0;
            // half the time the gap starts once the previous tick has come back,
            // so it lands right where the block turns idle
            if (after_result)
                while (pending != 0) @(negedge aclk);
            repeat (gap) @(negedge aclk);
        end
        s_tuser  = motor;
        s_tdata  = {target, count};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (motor < MOTORS) enc_pos[motor] = count;
    endtask

    // stop offering and let every outstanding tick come back
    task automatic drain_results;
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    // register write; valid is left high for a following write and lowered by the caller
    task automatic write_reg(logic [espc_pkg::CFG_IDX_W-1:0] index,
                             logic [espc_pkg::CFG_DATA_W-1:0] value);
        cfg_index = index;
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        if (index == espc_pkg::REG_COUNTS_TO_RPM) cur_rpm_scale = value;
    endtask

    // result side: random stalls once a result shows up, or always ready in eager stretches
    initial begin : result_sink
        int stall;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (rx_eager && !hold_req) begin
                m_tready = 1'b1;
            end else begin
                m_tready = 1'b0;
                do @(posedge aclk); while (!m_tvalid);
                @(negedge aclk);
                if (hold_req) begin
                    // long hold-off while the sender keeps pushing ticks
                    stall = HOLD_CYCLES;
                    hold_req = 1'b0;
                end else begin
                    stall = $urandom_range(0, MAX_GAP);
                end
                repeat (stall) @(negedge aclk);
                m_tready = 1'b1;
            end
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        int           kind;
        int           delta;
        int           offset;
        int           shift;
        logic [1:0]   motor;
        logic [15:0]  count;
        logic [31:0]  target;
        logic [23:0]  value;
        longint       meas_est;

        // synchronous reset, released at a falling edge
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed ticks at the reset register values
        send_tick(2'd0, 16'h0000, 32'h0000_0000);   // stopped: zero step, zero error
        send_tick(2'd0, 16'h7fff, 32'h7fff_ffff);   // largest forward step, largest target
        send_tick(2'd0, 16'hffff, 32'h8000_0000);   // step of -32768, most negative target
        send_tick(2'd0, 16'hffff, 32'h7fff_ffff);   // error sum pinned at the clamp
        send_tick(2'd0, 16'hffff, 32'h8000_0000);   // sum swings to the other clamp
        send_tick(2'd1, 16'hffff, 32'h0000_0000);   // counter wraps backward from zero
        send_tick(2'd1, 16'h0000, 32'h0000_0000);   // and forward through zero
        send_tick(2'd1, 16'h0100, 32'hffff_ff00);   // small negative target
        send_tick(2'd3, 16'hffff, 32'hffff_ffff);   // motor out of range
        send_tick(2'd3, 16'h0000, 32'h7fff_ffff);
        send_tick(2'd2, 16'h0000, 32'h0000_0000);   // motor 2 still untouched: stopped
        send_tick(2'd2, 16'h0064, 32'h0005_5000);   // near tracking, small error
        send_tick(2'd2, 16'h00c8, 32'hfff0_0000);   // reverse drive
        send_tick(2'd2, 16'h8000, 32'h0000_0000);
        send_tick(2'd0, 16'h5555, 32'haaaa_aaaa);
        send_tick(2'd1, 16'haaaa, 32'h5555_5555);

        for (int phase = 0; phase < PHASES; phase++) begin
            // registers only move with the block idle
            drain_results;
            for (int idx = 0; idx < 8; idx++) begin
                if (phase == 0) begin
                    value = '1;                      // every register at its top
                end else if (phase == 1) begin
                    value = '0;                      // and at zero
                end else if ($urandom_range(0, 3) == 0) begin
                    value = 24'($urandom);           // includes junk above 16-bit registers
                end else begin
                    case (3'(idx))
                        espc_pkg::REG_PROP_GAIN:     value = 24'($urandom_range(0, 200000));
                        espc_pkg::REG_INTEG_GAIN:    value = 24'($urandom_range(0, 30000));
                        espc_pkg::REG_DERIV_GAIN:    value = 24'($urandom_range(0, 3000));
                        espc_pkg::REG_INTEGRAL_LIM:  value = 24'($urandom_range(0, 6000));
                        espc_pkg::REG_PULSE_FULL:    value = 24'($urandom_range(0, 65535));
                        espc_pkg::REG_COUNTS_TO_RPM: value = 24'($urandom_range(1, 2000000));
                        REG_SPARE_LO, REG_SPARE_HI:  value = 24'($urandom);
                        default:                     value = 24'($urandom);
                    endcase
                end
                write_reg(3'(idx), value);
            end
            cfg_valid = 1'b0;

            // back-to-back stretches on each side, and one with both
            tx_eager = (phase == 2 || phase == 3);
            rx_eager = (phase == 2 || phase == 5);

            for (int n = 0; n < TICKS_PER_PHASE; n++) begin
                if (phase == 3 && n == 40) hold_req = 1'b1;
                if (phase == 4 && n == 80) drain_results;

                kind   = $urandom_range(0, 99);
                motor  = 2'($urandom_range(0, MOTORS - 1));
                count  = 16'($urandom);
                target = $urandom;
                if (kind < 5) begin
                    motor = 2'd3;                    // no such motor
                end else if (kind >= 20) begin
                    // tracked counter: mostly modest speeds, now and then a huge step
                    if ($urandom_range(0, 9) == 0)
                        delta = int'($urandom_range(0, 65535)) - 32768;
                    else
                        delta = int'($urandom_range(0, 600)) - 300;
                    count = enc_pos[motor] + 16'(delta);
                    if (kind >= 30) begin
                        // target close to the measured speed keeps the loop out of the clamp
                        meas_est = (longint'(delta) * cur_rpm_scale) / 256;
                        shift    = $urandom_range(4, 20);
                        offset   = int'($urandom_range(0, 2 << shift)) - (1 << shift);
                        target   = 32'(meas_est + offset);
                    end
                end
                send_tick(motor, count, target);
            end
        end

        // wait out the last results, then a latency more for anything spurious
        drain_results;
        repeat (LATENCY + 30) @(negedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/espc_pkg.sv
hw/rtl/espc_mul.sv
hw/rtl/espc_div.sv
hw/rtl/encoder_speed_pid_pwm_controller.sv
test/encoder_speed_pid_pwm_controller_checker.sv
test/encoder_speed_pid_pwm_controller_tb.sv
